// File: rtl/hcmru_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the header context MRU table.
// No dependencies; imported by the cell and the top level.
package hcmru_pkg;

    localparam int CodeWidth = 62;
    localparam int CidMaxBytes = 20;
    localparam int DataWidth = 376;
    localparam int CtxWidth = 372;

    localparam logic [1:0] REQ_RESERVE = 2'd0;
    localparam logic [1:0] REQ_BY_CODE = 2'd1;
    localparam logic [1:0] REQ_BY_PEER = 2'd2;

    // Declared from the top bit down so the code lands in the lowest bits.
    typedef struct packed {
        logic [31:0]          cid_word2;
        logic [63:0]          cid_word1;
        logic [63:0]          cid_word0;
        logic [4:0]           cid_length;
        logic [15:0]          port;
        logic [63:0]          addr_low;
        logic [63:0]          addr_high;
        logic                 ipv6;
        logic [CodeWidth-1:0] code;
    } ctx_t;

    typedef struct packed {
        logic cmp_en;
        logic by_code;
        logic move_en;
    } cell_ctrl_t;

    // Brings a raw request into the stored form: IPv4 addresses lose their
    // upper bits, the length saturates and bytes past it become zero.
    function automatic ctx_t normalize(input ctx_t raw);
        ctx_t c;
        logic [4:0] len;
        c = raw;
        len = (raw.cid_length > 5'(CidMaxBytes)) ? 5'(CidMaxBytes) : raw.cid_length;
        c.cid_length = len;
        if (!raw.ipv6) begin
            c.addr_high = '0;
            c.addr_low = {32'd0, raw.addr_low[31:0]};
        end
        for (int b = 0; b < 8; b++) begin
            if (len <= 5'(b)) begin
                c.cid_word0[63 - 8 * b -: 8] = 8'd0;
            end
            if (len <= 5'(b + 8)) begin
                c.cid_word1[63 - 8 * b -: 8] = 8'd0;
            end
        end
        for (int b = 0; b < 4; b++) begin
            if (len <= 5'(b + 16)) begin
                c.cid_word2[31 - 8 * b -: 8] = 8'd0;
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/hcmru_cell.sv
`timescale 1ns / 1ps
// One slot of the recency chain: holds a context, compares it with the query
// and takes its neighbor's context when the chain shifts. Uses hcmru_pkg.
module hcmru_cell
    import hcmru_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  ctx_t       query,
    input  ctx_t       prev_entry,
    input  logic       prev_valid,
    input  logic       seen_in,
    output ctx_t       entry,
    output logic       valid,
    output logic       match,
    output logic       seen_out
);

    ctx_t entry_reg;
    logic valid_reg;
    logic match_reg;
    logic match_next;
    logic shift;

    always_comb begin
        if (ctrl.by_code) begin
            match_next = valid_reg && (entry_reg.code == query.code);
        end else begin
            match_next = valid_reg
                && (entry_reg.ipv6 == query.ipv6)
                && (entry_reg.addr_high == query.addr_high)
                && (entry_reg.addr_low == query.addr_low)
                && (entry_reg.port == query.port)
                && (entry_reg.cid_length == query.cid_length)
                && (entry_reg.cid_word0 == query.cid_word0)
                && (entry_reg.cid_word1 == query.cid_word1)
                && (entry_reg.cid_word2 == query.cid_word2);
        end
    end

    // Every slot up to and including the first match moves back by one.
    assign shift = ctrl.move_en && !seen_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end else begin
            if (ctrl.cmp_en) begin
                match_reg <= match_next;
            end
            if (shift) begin
                valid_reg <= prev_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (shift) begin
            entry_reg <= prev_entry;
        end
    end

    assign entry = entry_reg;
    assign valid = valid_reg;
    assign match = match_reg;
    assign seen_out = seen_in || match_reg;

endmodule

// File: rtl/header_context_mru_table.sv
`timescale 1ns / 1ps
// Top level of the header context MRU table: request register, the chain of
// slot cells and the result register. Uses hcmru_pkg and hcmru_cell.
//
//  channel  | direction | tdata                      | tuser
//  ---------+-----------+----------------------------+--------------------------
//  s_       | in        | context fields, 376 bits   | req_type (2)
//  m_       | out       | found context, 376 bits    | hit (bit 0), entry_dropped
//
// A transaction runs in order: the request is registered, every cell registers
// its compare, then the chain shifts and the result register loads. The next
// request is accepted once the shift is done. Reset clears the valid and match
// bits, not the stored contexts, so no clearing pass is needed. A result waiting
// on m_tready holds the shift cycle until the result register frees up.
module header_context_mru_table
    import hcmru_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // ctx_code, is_ipv6, addr_high, addr_low, port_number, cid_length,
    // cid_word0, cid_word1, cid_word2, zero pad
    input  logic [DataWidth-1:0] s_tdata,
    // req_type
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // found_code, found_ipv6, found_addr_high, found_addr_low, found_port,
    // found_cid_length, found_cid_word0, found_cid_word1, found_cid_word2, zero pad
    output logic [DataWidth-1:0] m_tdata,
    // hit, entry_dropped
    output logic [1:0]           m_tuser
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_MOVE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    ctx_t       query_reg;
    logic [1:0] req_reg;
    ctx_t       out_ctx_reg;
    logic       out_hit_reg;
    logic       out_drop_reg;
    logic       out_valid_reg;

    ctx_t                   entry_arr [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_vec;
    logic [TABLE_DEPTH-1:0] match_vec;
    logic [TABLE_DEPTH:0]   seen_vec;
    cell_ctrl_t             ctrl;
    ctx_t                   found;
    ctx_t                   front_entry;
    logic                   is_reserve;
    logic                   is_lookup;
    logic                   lookup_hit;
    logic                   out_free;
    logic                   finish;

    assign s_tready   = (state_reg == S_IDLE);
    assign is_reserve = (req_reg == REQ_RESERVE);
    assign is_lookup  = (req_reg == REQ_BY_CODE) || (req_reg == REQ_BY_PEER);
    assign lookup_hit = is_lookup && seen_vec[TABLE_DEPTH];
    assign out_free   = !out_valid_reg || m_tready;
    assign finish     = (state_reg == S_MOVE) && out_free;

    assign ctrl.cmp_en  = (state_reg == S_CMP);
    assign ctrl.by_code = (req_reg != REQ_BY_PEER);
    assign ctrl.move_en = finish && (is_reserve || lookup_hit);

    // Only the first matching slot survives the masking, so an OR collects it.
    always_comb begin
        found = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (match_vec[i] && !seen_vec[i]) begin
                found = found | entry_arr[i];
            end
        end
    end

    assign front_entry = is_reserve ? query_reg : found;
    assign seen_vec[0] = 1'b0;

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_head
            hcmru_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .query      (query_reg),
                .prev_entry (front_entry),
                .prev_valid (1'b1),
                .seen_in    (seen_vec[i]),
                .entry      (entry_arr[i]),
                .valid      (valid_vec[i]),
                .match      (match_vec[i]),
                .seen_out   (seen_vec[i+1])
            );
        end else begin : g_body
            hcmru_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .query      (query_reg),
                .prev_entry (entry_arr[i-1]),
                .prev_valid (valid_vec[i-1]),
                .seen_in    (seen_vec[i]),
                .entry      (entry_arr[i]),
                .valid      (valid_vec[i]),
                .match      (match_vec[i]),
                .seen_out   (seen_vec[i+1])
            );
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                state_next = S_MOVE;
            end
            S_MOVE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (finish) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            query_reg <= normalize(ctx_t'(s_tdata[CtxWidth-1:0]));
            req_reg   <= s_tuser;
        end
        if (finish) begin
            out_hit_reg  <= is_reserve || lookup_hit;
            out_drop_reg <= is_reserve && !seen_vec[TABLE_DEPTH]
                            && valid_vec[TABLE_DEPTH-1];
            if (is_reserve || lookup_hit) begin
                out_ctx_reg <= front_entry;
            end else begin
                out_ctx_reg <= '0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(DataWidth - CtxWidth){1'b0}}, out_ctx_reg};
    assign m_tuser  = {out_drop_reg, out_hit_reg};

`ifndef NO_ASSERTIONS
    // Valid slots always form a prefix of the chain.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((valid_vec >> 1) & ~valid_vec) == '0)
        else $error("valid slots do not form a prefix");

    // Reserve keeps codes unique, so a code compare finds at most one slot.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MOVE && ctrl.by_code) |-> $onehot0(match_vec))
        else $error("duplicate code in table");

    // After a shift the front slot always holds a context.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.move_en |=> valid_vec[0])
        else $error("front slot empty after shift");

    // A result is loaded only when the result register is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        finish |-> (!m_tvalid || m_tready))
        else $error("result register overwritten");
`endif

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for header_context_mru_table: a directed table, then random traffic.
// The table contents are tracked in a recency-ordered queue. Depends on hcmru_pkg and the RTL.
module tb_top;
    import hcmru_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int POOL_SIZE = 24;
    localparam int RANDOM_ITEMS = 1180;
    localparam int HOLD_CYCLES = 250;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    typedef struct packed {
        logic dropped;
        logic hit;
        ctx_t ctx;
    } lookup_result_t;

    typedef struct {
        logic [1:0]     req;
        ctx_t           ctx;
        bit             typed;
        lookup_result_t want;
    } stimulus_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [DataWidth-1:0] s_tdata = '0;
    logic [1:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [DataWidth-1:0] m_tdata;
    logic [1:0]           m_tuser;

    logic calm = 1'b0;
    logic long_hold = 1'b0;

    // Index 0 holds the most recent context, as slot 0 does in the table.
    ctx_t           recency_list[$];
    lookup_result_t expected_lookups[$];
    stimulus_row_t  directed_rows[$];
    int             requests_accepted = 0;
    int             results_checked = 0;
    int             mismatch_count = 0;

    header_context_mru_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #1000000;
        $display("[header_context_mru_table] ERROR");
        $finish;
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Stored form of a context: IPv4 drops the upper address bits, the CID
    // length saturates and CID bytes past the length read as zero.
    function automatic ctx_t canonical_context(input ctx_t raw);
        ctx_t c;
        logic [159:0] keep;
        logic [159:0] cid;
        int unsigned n;
        c = raw;
        n = (raw.cid_length > 5'(CidMaxBytes)) ? CidMaxBytes : raw.cid_length;
        c.cid_length = 5'(n);
        if (!c.ipv6) begin
            c.addr_high = '0;
            c.addr_low[63:32] = '0;
        end
        keep = {160{1'b1}} << (8 * (CidMaxBytes - n));
        cid = {c.cid_word0, c.cid_word1, c.cid_word2} & keep;
        {c.cid_word0, c.cid_word1, c.cid_word2} = cid;
        return c;
    endfunction

    function automatic lookup_result_t predict_lookup(input logic [1:0] req, input ctx_t raw);
        lookup_result_t r;
        ctx_t q;
        ctx_t a;
        int idx;
        r = '0;
        q = canonical_context(raw);
        idx = -1;
        case (req) inside
            REQ_RESERVE: begin
                for (int i = recency_list.size() - 1; i >= 0; i--) begin
                    if (recency_list[i].code == q.code) begin
                        recency_list.delete(i);
                    end
                end
                if (recency_list.size() >= TABLE_DEPTH) begin
                    void'(recency_list.pop_back());
                    r.dropped = 1'b1;
                end
                recency_list.push_front(q);
                r.hit = 1'b1;
                r.ctx = q;
            end
            REQ_BY_CODE, REQ_BY_PEER: begin
                for (int i = 0; i < recency_list.size(); i++) begin
                    a = recency_list[i];
                    if (req == REQ_BY_PEER) begin
                        // Peer match covers every field except the code.
                        a.code = q.code;
                    end
                    if (idx < 0 && (req == REQ_BY_CODE ? a.code == q.code : a == q)) begin
                        idx = i;
                    end
                end
                if (idx >= 0) begin
                    r.hit = 1'b1;
                    r.ctx = recency_list[idx];
                    recency_list.delete(idx);
                    recency_list.push_front(r.ctx);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic ctx_t mk_ctx(input logic [61:0] code, input logic ipv6,
                                    input logic [63:0] ah, input logic [63:0] al,
                                    input logic [15:0] port, input logic [4:0] len,
                                    input logic [63:0] w0, input logic [63:0] w1,
                                    input logic [31:0] w2);
        ctx_t c;
        c.code = code;
        c.ipv6 = ipv6;
        c.addr_high = ah;
        c.addr_low = al;
        c.port = port;
        c.cid_length = len;
        c.cid_word0 = w0;
        c.cid_word1 = w1;
        c.cid_word2 = w2;
        return c;
    endfunction

    function automatic ctx_t fresh_context();
        ctx_t c;
        int r;
        if ($urandom_range(1) != 0) begin
            c.code = 62'({$urandom, $urandom});
        end else begin
            c.code = 62'($urandom_range(0, 40));
        end
        c.ipv6 = 1'($urandom_range(1));
        c.addr_high = {$urandom, $urandom};
        c.addr_low = {$urandom, $urandom};
        c.port = 16'($urandom);
        r = $urandom_range(0, 9);
        if (r < 3) begin
            c.cid_length = 5'(8 * $urandom_range(0, 2));
        end else if (r < 4) begin
            c.cid_length = 5'd20;
        end else begin
            c.cid_length = 5'($urandom_range(0, 31));
        end
        c.cid_word0 = {$urandom, $urandom};
        c.cid_word1 = {$urandom, $urandom};
        c.cid_word2 = $urandom;
        return c;
    endfunction

    // Randomizes every bit that the table ignores, so the stored form is unchanged.
    function automatic ctx_t disguise(input ctx_t t);
        ctx_t c;
        logic [159:0] keep;
        logic [159:0] noise;
        int unsigned n;
        c = t;
        n = (t.cid_length > 5'(CidMaxBytes)) ? CidMaxBytes : t.cid_length;
        if (!c.ipv6) begin
            c.addr_high = {$urandom, $urandom};
            c.addr_low[63:32] = $urandom;
        end
        keep = {160{1'b1}} << (8 * (CidMaxBytes - n));
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
        {c.cid_word0, c.cid_word1, c.cid_word2} =
            ({c.cid_word0, c.cid_word1, c.cid_word2} & keep) | (noise & ~keep);
        if (n == CidMaxBytes && $urandom_range(1) != 0) begin
            c.cid_length = 5'($urandom_range(20, 31));
        end
        return c;
    endfunction

    task automatic add_row(input logic [1:0] req, input ctx_t ctx, input bit typed,
                           input lookup_result_t want);
        stimulus_row_t row;
        row.req = req;
        row.ctx = ctx;
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endtask

    task automatic offer(input logic [1:0] req, input ctx_t raw, input bit typed,
                         input lookup_result_t want);
        int gap;
        lookup_result_t predicted;
        gap = calm ? 0 : idle_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= DataWidth'(raw);
        do @(posedge aclk); while (!s_tready);
        predicted = predict_lookup(req, raw);
        expected_lookups.push_back(typed ? want : predicted);
        requests_accepted++;
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("result %0d: %s expected %h, got %h",
                         results_checked, name, want, got);
            end
        end
    endfunction

    task automatic check_lookup();
        lookup_result_t want;
        lookup_result_t got;
        got.ctx = m_tdata[CtxWidth-1:0];
        got.hit = m_tuser[0];
        got.dropped = m_tuser[1];
        if (expected_lookups.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("result %0d arrived with nothing outstanding", results_checked);
            end
        end else begin
            want = expected_lookups.pop_front();
            check_field("hit", 64'(want.hit), 64'(got.hit));
            check_field("entry_dropped", 64'(want.dropped), 64'(got.dropped));
            check_field("code", 64'(want.ctx.code), 64'(got.ctx.code));
            check_field("ipv6", 64'(want.ctx.ipv6), 64'(got.ctx.ipv6));
            check_field("addr_high", want.ctx.addr_high, got.ctx.addr_high);
            check_field("addr_low", want.ctx.addr_low, got.ctx.addr_low);
            check_field("port", 64'(want.ctx.port), 64'(got.ctx.port));
            check_field("cid_length", 64'(want.ctx.cid_length), 64'(got.ctx.cid_length));
            check_field("cid_word0", want.ctx.cid_word0, got.ctx.cid_word0);
            check_field("cid_word1", want.ctx.cid_word1, got.ctx.cid_word1);
            check_field("cid_word2", 64'(want.ctx.cid_word2), 64'(got.ctx.cid_word2));
        end
        results_checked++;
    endtask

    initial begin : result_sink
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                check_lookup();
                stall = calm ? 0 : idle_gap();
            end else if (stall > 0) begin
                stall--;
            end
            m_tready <= !long_hold && stall == 0;
        end
    end

    // One long stall of the result channel so the request side backs up.
    initial begin : result_hold
        wait (requests_accepted >= 400);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        long_hold <= 1'b0;
    end

    initial begin : request_source
        ctx_t peer_pool[POOL_SIZE];
        ctx_t c;
        int j;
        int k;
        int pick;

        // Lookups on an empty table and unknown requests return all zeros.
        add_row(REQ_BY_CODE, mk_ctx('0, 1'b0, '0, '0, '0, '0, '0, '0, '0), 1'b1, '0);
        add_row(REQ_BY_PEER, mk_ctx('1, 1'b1, '1, '1, '1, 5'd20, '1, '1, '1), 1'b1, '0);
        add_row(REQ_UNKNOWN, mk_ctx('1, 1'b1, '1, '1, '1, '1, '1, '1, '1), 1'b1, '0);
        add_row(REQ_RESERVE, mk_ctx('1, 1'b0, '1, '1, '1, 5'd31, '1, '1, '1), 1'b0, '0);
        add_row(REQ_RESERVE, mk_ctx('0, 1'b1, '1, '1, '0, 5'd0, '1, '1, '1), 1'b0, '0);
        add_row(REQ_RESERVE, mk_ctx(62'd1, 1'b1, '0, '0, 16'd1, 5'd5,
                                    64'h0123_4567_89AB_CDEF, 64'h5555_5555_5555_5555,
                                    32'hDEAD_BEEF), 1'b0, '0);
        add_row(REQ_BY_CODE, mk_ctx('1, 1'b0, '0, '0, '0, '0, '0, '0, '0), 1'b0, '0);
        add_row(REQ_BY_PEER, mk_ctx(62'd7, 1'b0, 64'h1234, 64'h0BAD_F00D_FFFF_FFFF, '1,
                                    5'd25, '1, '1, '1), 1'b0, '0);
        add_row(REQ_BY_PEER, mk_ctx(62'd9, 1'b1, '0, '0, 16'd1, 5'd5,
                                    64'h0123_4567_89FF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA,
                                    32'd0), 1'b0, '0);
        add_row(REQ_BY_PEER, mk_ctx(62'd9, 1'b1, '0, '0, 16'd1, 5'd6,
                                    64'h0123_4567_89AB_CDEF, '0, '0), 1'b0, '0);
        add_row(REQ_RESERVE, mk_ctx(62'd1, 1'b0, '0, 64'hC0A8_0001, 16'd443, 5'd8,
                                    64'hFEDC_BA98_7654_3210, '0, '0), 1'b0, '0);
        add_row(REQ_BY_PEER, mk_ctx(62'd1, 1'b1, '0, '0, 16'd1, 5'd5,
                                    64'h0123_4567_89AB_CDEF, '0, '0), 1'b0, '0);
        add_row(REQ_BY_CODE, mk_ctx(62'd1, 1'b0, '0, '0, '0, '0, '0, '0, '0), 1'b0, '0);
        add_row(REQ_RESERVE, mk_ctx(62'd2, 1'b0, '0, 64'h0A00_0001, 16'd80, 5'd16,
                                    '1, '1, '1), 1'b0, '0);
        add_row(REQ_RESERVE, mk_ctx(62'd3, 1'b1, 64'h2001_0DB8_0000_0000, 64'd1,
                                    16'h8000, 5'd20, 64'h8000_0000_0000_0001, 64'd1,
                                    32'h8000_0001), 1'b0, '0);
        add_row(REQ_BY_PEER, mk_ctx('0, 1'b0, '1, '1, '0, '0, '1, '1, '1), 1'b0, '0);
        add_row(REQ_UNKNOWN, mk_ctx('1, 1'b1, '1, '1, '1, '1, '1, '1, '1), 1'b1, '0);
        add_row(REQ_BY_CODE, mk_ctx('0, 1'b1, '1, '1, '1, '1, '1, '1, '1), 1'b0, '0);
        add_row(REQ_BY_CODE, mk_ctx(62'h2AAA_AAAA_AAAA_AAAA, 1'b0, '0, '0, '0, '0, '0,
                                    '0, '0), 1'b0, '0);
        add_row(REQ_RESERVE, mk_ctx(62'h1555_5555_5555_5555, 1'b1, 64'h5555_5555_5555_5555,
                                    64'hAAAA_AAAA_AAAA_AAAA, 16'h5A5A, 5'd20,
                                    64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                                    32'h5555_5555), 1'b0, '0);
        add_row(REQ_BY_PEER, mk_ctx('0, 1'b1, '1, '1, '0, 5'd0, '0, '0, '0), 1'b0, '0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            offer(directed_rows[i].req, directed_rows[i].ctx, directed_rows[i].typed,
                  directed_rows[i].want);
        end

        // More contexts than slots, so refilling the table drops old entries.
        for (int i = 0; i < POOL_SIZE; i++) begin
            peer_pool[i] = fresh_context();
            offer(REQ_RESERVE, disguise(peer_pool[i]), 1'b0, '0);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm <= (n >= 150 && n < 300);
            if (n == 800) begin
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (expected_lookups.size() != 0);
            end
            j = $urandom_range(POOL_SIZE - 1);
            pick = $urandom_range(99);
            if (pick < 35) begin
                if ($urandom_range(9) == 0) begin
                    // Refresh a context; it shares either a code or a peer with another.
                    k = $urandom_range(POOL_SIZE - 1);
                    c = fresh_context();
                    if ($urandom_range(1) != 0) begin
                        c.code = peer_pool[k].code;
                    end else begin
                        c = peer_pool[k];
                        c.code = 62'({$urandom, $urandom});
                    end
                    peer_pool[j] = c;
                end
                offer(REQ_RESERVE, disguise(peer_pool[j]), 1'b0, '0);
            end else if (pick < 60) begin
                c = fresh_context();
                c.code = peer_pool[j].code;
                offer(REQ_BY_CODE, c, 1'b0, '0);
            end else if (pick < 85) begin
                c = disguise(peer_pool[j]);
                c.code = 62'({$urandom, $urandom});
                offer(REQ_BY_PEER, c, 1'b0, '0);
            end else if (pick < 92) begin
                // A near miss: one bit differs inside the compared fields.
                c = disguise(peer_pool[j]);
                if (c.cid_length != 0 && $urandom_range(1) != 0) begin
                    c.cid_word0[63] = !c.cid_word0[63];
                end else begin
                    c.port = c.port ^ 16'(1 << $urandom_range(15));
                end
                offer(REQ_BY_PEER, c, 1'b0, '0);
            end else if (pick < 96) begin
                offer(REQ_RESERVE, fresh_context(), 1'b0, '0);
            end else begin
                offer(REQ_UNKNOWN, fresh_context(), 1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;
        calm <= 1'b0;

        while (expected_lookups.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("[header_context_mru_table] OK");
        end else begin
            $display("[header_context_mru_table] ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/hcmru_pkg.sv
rtl/hcmru_cell.sv
rtl/header_context_mru_table.sv
sim/tb_top.sv
